@@ rtl/wpst_pkg.sv @@
// Package for the wildcard pattern select table.
// Holds function codes, the fixed field sizes and the shared status struct; no dependencies.
`default_nettype none
package wpst_pkg;
	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_SELECT = 2'd1;
	localparam logic [1:0] FUNC_REMOVE = 2'd2;
	localparam int TAG_FIELD_BITS = 16;
	localparam int INDEX_FIELD_BITS = 6;
	localparam int COUNT_FIELD_BITS = 7;
	localparam int CFG_BITS = 3;
	// Tag width, index range and coordinate count are tied to the port layout.
	localparam int TAG_BITS = TAG_FIELD_BITS;
	localparam int INDEX_LIMIT = 64;
	localparam int COORD_COUNT = 4;

	typedef struct packed {
		logic busy;
		logic res_pending;
	} wpst_stat_t;
endpackage
`default_nettype wire

@@ rtl/wildcard_pattern_select_table.sv @@
// Wildcard pattern select table: top level with the slot sequencer.
// Depends on wpst_pkg and wpst_ram.
// A select walks all SLOT_COUNT slots through the slot RAM (one read per cycle, registered
// read data), then scans INDEX_LIMIT mark bits one per cycle, pausing while a result waits
// for the receiver. A remove gives its count when its walk ends; an insert or unused-code
// item is answered straight from idle. One item at a time: the next input transfer is taken
// the cycle after the last result transfer.
// Reset clears the valid bits, marks and control; RAM holds no reset.
`default_nettype none
module wildcard_pattern_select_table #(
	parameter int SLOT_COUNT  = 64
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_we,
	input  wire [wpst_pkg::CFG_BITS-1:0]          cfg_wdata,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire [1:0]                             func,
	input  wire [wpst_pkg::INDEX_FIELD_BITS-1:0]  entry_index,
	input  wire [wpst_pkg::TAG_FIELD_BITS-1:0]    tag_0,
	input  wire [wpst_pkg::TAG_FIELD_BITS-1:0]    tag_1,
	input  wire [wpst_pkg::TAG_FIELD_BITS-1:0]    tag_2,
	input  wire [wpst_pkg::TAG_FIELD_BITS-1:0]    tag_3,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic                                  status,
	output logic                                  has_match,
	output logic [wpst_pkg::INDEX_FIELD_BITS-1:0] match_index,
	output logic [wpst_pkg::COUNT_FIELD_BITS-1:0] removed_count,
	output logic                                  is_last
);
	import wpst_pkg::*;

	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int IW = (INDEX_LIMIT > 1) ? $clog2(INDEX_LIMIT) : 1;
	localparam int PW = TAG_BITS * COORD_COUNT;
	localparam int RW = INDEX_FIELD_BITS + PW;
	localparam logic [TAG_BITS-1:0] UNKNOWN = '1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WALK  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_FINAL = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0] state_q;
	logic [CFG_BITS-1:0] coords_q;
	logic [SLOT_COUNT-1:0] valid_q;
	logic [INDEX_LIMIT-1:0] marks_q;
	logic [1:0] func_q;
	logic [INDEX_FIELD_BITS-1:0] idx_q;
	logic [PW-1:0] tags_q;
	logic [SW:0] addr_q;      // read address counter, top bit marks end of sweep
	logic rd_s1;              // a read issued last cycle is now on rdata
	logic [SW-1:0] rd_addr_s1;
	logic [IW:0] scan_q;
	logic [COUNT_FIELD_BITS-1:0] cnt_q;
	logic found_q;            // a marked index has been found in the scan
	wpst_stat_t stat;

	// Slot RAM: owner index and pattern.
	logic ram_we;
	logic [SW-1:0] ram_waddr, ram_raddr;
	logic [RW-1:0] ram_wdata, ram_rdata;

	wpst_ram #(.WIDTH(RW), .DEPTH(SLOT_COUNT)) u_slots (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// Lowest free slot found by a priority search over the valid bits.
	logic free_any;
	logic [SW-1:0] free_slot;
	always_comb begin
		free_any = 1'b0;
		free_slot = '0;
		for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
			if (!valid_q[s]) begin
				free_any = 1'b1;
				free_slot = SW'(s);
			end
		end
	end

	// Pattern compare of the slot just read against the held observation.
	logic [INDEX_FIELD_BITS-1:0] rd_owner;
	logic [PW-1:0] rd_pat;
	logic hit;
	logic [2:0] ncoord;
	always_comb begin
		rd_owner = ram_rdata[RW-1 -: INDEX_FIELD_BITS];
		rd_pat = ram_rdata[PW-1:0];
		ncoord = (coords_q > 3'(COORD_COUNT)) ? 3'(COORD_COUNT) : coords_q;
		hit = 1'b1;
		for (int d = 0; d < COORD_COUNT; d++) begin
			if (3'(d) < ncoord) begin
				if (tags_q[d*TAG_BITS +: TAG_BITS] != UNKNOWN &&
				    rd_pat[d*TAG_BITS +: TAG_BITS] != UNKNOWN &&
				    tags_q[d*TAG_BITS +: TAG_BITS] != rd_pat[d*TAG_BITS +: TAG_BITS]) begin
					hit = 1'b0;
				end
			end
		end
	end

	logic owner_ok;
	assign owner_ok = 32'(rd_owner) < 32'(INDEX_LIMIT);
	logic idx_ok;
	assign idx_ok = 32'(idx_q) < 32'(INDEX_LIMIT);

	assign ram_raddr = addr_q[SW-1:0];
	assign ram_we    = (state_q == ST_IDLE) && in_valid && in_ready && func == FUNC_INSERT
	                   && (32'(entry_index) < 32'(INDEX_LIMIT)) && free_any;
	assign ram_waddr = free_slot;
	assign ram_wdata = {entry_index, tag_3[TAG_BITS-1:0], tag_2[TAG_BITS-1:0],
	                    tag_1[TAG_BITS-1:0], tag_0[TAG_BITS-1:0]};

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.res_pending = out_valid;
	assign in_ready = !stat.busy && !stat.res_pending;

	logic [IW-1:0] scan_idx;
	assign scan_idx = scan_q[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			coords_q <= 3'd4;
			valid_q <= '0;
			marks_q <= '0;
			out_valid <= 1'b0;
			rd_s1 <= 1'b0;
			addr_q <= '0;
			scan_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				coords_q <= cfg_wdata;
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						func_q <= func;
						idx_q <= entry_index;
						tags_q <= {tag_3[TAG_BITS-1:0], tag_2[TAG_BITS-1:0],
						           tag_1[TAG_BITS-1:0], tag_0[TAG_BITS-1:0]};
						cnt_q <= '0;
						marks_q <= '0;
						addr_q <= '0;
						found_q <= 1'b0;
						rd_s1 <= 1'b0;
						if (func == FUNC_INSERT) begin
							if (ram_we) valid_q[free_slot] <= 1'b1;
							status <= (32'(entry_index) < 32'(INDEX_LIMIT)) && !free_any;
							has_match <= 1'b0; match_index <= '0;
							removed_count <= '0; is_last <= 1'b1;
							out_valid <= 1'b1;
						end else if (func == FUNC_SELECT || func == FUNC_REMOVE) begin
							state_q <= ST_WALK;
						end else begin
							status <= 1'b0; has_match <= 1'b0; match_index <= '0;
							removed_count <= '0; is_last <= 1'b1;
							out_valid <= 1'b1;
						end
					end
				end
				ST_WALK: begin
					if (!addr_q[SW] && 32'(addr_q) < 32'(SLOT_COUNT)) begin
						addr_q <= addr_q + 1'b1;
						rd_addr_s1 <= addr_q[SW-1:0];
						rd_s1 <= 1'b1;
					end else begin
						rd_s1 <= 1'b0;
					end
					if (rd_s1 && valid_q[rd_addr_s1]) begin
						if (func_q == FUNC_REMOVE) begin
							if (rd_owner == idx_q && idx_ok) begin
								valid_q[rd_addr_s1] <= 1'b0;
								cnt_q <= cnt_q + 1'b1;
							end
						end else if (owner_ok && hit) begin
							marks_q[rd_owner[IW-1:0]] <= 1'b1;
						end
					end
					if (!rd_s1 && (addr_q[SW] || 32'(addr_q) >= 32'(SLOT_COUNT))) begin
						if (func_q == FUNC_REMOVE) begin
							status <= 1'b0; has_match <= 1'b0; match_index <= '0;
							removed_count <= cnt_q; is_last <= 1'b1;
							out_valid <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							scan_q <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// Emit marked indices one at a time; a match is held back until the
					// next one is found so the last one can carry is_last.
					if (!out_valid || out_ready) begin
						if (32'(scan_q) < 32'(INDEX_LIMIT)) begin
							scan_q <= scan_q + 1'b1;
							if (marks_q[scan_idx]) begin
								if (found_q) begin
									status <= 1'b0; has_match <= 1'b1;
									match_index <= INDEX_FIELD_BITS'(cnt_q);
									removed_count <= '0; is_last <= 1'b0;
									out_valid <= 1'b1;
								end
								cnt_q <= COUNT_FIELD_BITS'(scan_idx);
								found_q <= 1'b1;
							end
						end else begin
							status <= 1'b0; has_match <= found_q;
							match_index <= found_q ? INDEX_FIELD_BITS'(cnt_q) : '0;
							removed_count <= '0; is_last <= 1'b1;
							out_valid <= 1'b1;
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (out_valid && out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/wpst_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module wpst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire                                          clk,
	input  wire                                          we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  wire [WIDTH-1:0]                              wdata,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/wpst_checker.sv @@
// Port-level checker for the wildcard pattern select table, with its bind.
// Depends on the top level's ports only.
`default_nettype none
module wpst_checker (
	input wire clk,
	input wire arst_n,
	input wire in_ready,
	input wire out_valid,
	input wire out_ready,
	input wire has_match,
	input wire is_last,
	input wire status,
	input wire [6:0] removed_count
);
	// No new transfer is taken while a result is still offered.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	// A result without a match always ends its run.
	a_nomatch_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_match) |-> is_last) else $error("no-match result not last");
	// A match result carries no status nor count.
	a_match_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && has_match) |-> (!status && removed_count == 7'd0))
		else $error("match result has stray fields");
	// A result stays offered until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind wildcard_pattern_select_table wpst_checker u_wpst_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .has_match(has_match),
	.is_last(is_last), .status(status), .removed_count(removed_count)
);
`default_nettype wire

@@ sim/tb_wildcard_pattern_select_table.sv @@
// Testbench for the wildcard pattern select table: directed table, a fill-and-clear pass, then random traffic.
// Depends on wpst_pkg and the wildcard_pattern_select_table RTL; checks against a local predictor.
`default_nettype none
module tb_wildcard_pattern_select_table;
	import wpst_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [15:0] TAG_UNKNOWN = 16'hFFFF;
	localparam int DIRECTED_ROWS = 20;
	localparam int RANDOM_ITEMS = 384;

	// One input item as it is driven onto the ports.
	typedef struct packed {
		logic [1:0] func;
		logic [5:0] entry_index;
		logic [15:0] tag_0;
		logic [15:0] tag_1;
		logic [15:0] tag_2;
		logic [15:0] tag_3;
	} request_t;

	// One result item as it comes back from the block.
	typedef struct packed {
		logic status;
		logic has_match;
		logic [5:0] match_index;
		logic [6:0] removed_count;
		logic is_last;
	} reply_t;

	// A directed row carries a typed-in reply only when it is obvious.
	typedef struct packed {
		request_t req;
		logic known;
		reply_t reply;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_BITS-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	request_t drive_req = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	reply_t got;

	// Predictor state: the slot table and the current coordinate count.
	logic slot_used [64];
	logic [5:0] slot_index [64];
	logic [15:0] slot_tags [64][4];
	int coords_cfg;

	reply_t pending_replies [$];
	int mismatches = 0;
	int out_wait = 0;
	logic stimulus_done = 1'b0;
	logic long_hold = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	wildcard_pattern_select_table DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(drive_req.func), .entry_index(drive_req.entry_index),
		.tag_0(drive_req.tag_0), .tag_1(drive_req.tag_1),
		.tag_2(drive_req.tag_2), .tag_3(drive_req.tag_3),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(got.status), .has_match(got.has_match), .match_index(got.match_index),
		.removed_count(got.removed_count), .is_last(got.is_last)
	);

	function automatic reply_t make_reply(logic st, logic hm, logic [5:0] mi,
			logic [6:0] rc, logic lst);
		reply_t r;
		r.status = st;
		r.has_match = hm;
		r.match_index = mi;
		r.removed_count = rc;
		r.is_last = lst;
		return r;
	endfunction

	// Applies one item to the predicted table and queues the replies it must produce.
	task automatic predict_table_op(input request_t rq);
		logic [15:0] obs [4];
		logic [63:0] hits;
		int used;
		int freed;
		int slot;
		int last_hit;
		logic ok;
		obs[0] = rq.tag_0;
		obs[1] = rq.tag_1;
		obs[2] = rq.tag_2;
		obs[3] = rq.tag_3;
		used = (coords_cfg > 4) ? 4 : coords_cfg;
		case (rq.func)
			FUNC_INSERT: begin
				slot = -1;
				for (int s = 0; s < 64; s++)
					if (slot < 0 && !slot_used[s])
						slot = s;
				if (slot >= 0) begin
					slot_used[slot] = 1'b1;
					slot_index[slot] = rq.entry_index;
					for (int d = 0; d < 4; d++)
						slot_tags[slot][d] = obs[d];
				end
				pending_replies.push_back(make_reply(slot < 0, 1'b0, '0, '0, 1'b1));
			end
			FUNC_REMOVE: begin
				freed = 0;
				for (int s = 0; s < 64; s++)
					if (slot_used[s] && slot_index[s] == rq.entry_index) begin
						slot_used[s] = 1'b0;
						freed++;
					end
				pending_replies.push_back(make_reply(1'b0, 1'b0, '0, freed[6:0], 1'b1));
			end
			FUNC_SELECT: begin
				hits = '0;
				for (int s = 0; s < 64; s++) begin
					ok = slot_used[s];
					for (int d = 0; d < used; d++)
						if (obs[d] != TAG_UNKNOWN && slot_tags[s][d] != TAG_UNKNOWN &&
								obs[d] != slot_tags[s][d])
							ok = 1'b0;
					if (ok)
						hits[slot_index[s]] = 1'b1;
				end
				last_hit = -1;
				for (int i = 0; i < 64; i++)
					if (hits[i])
						last_hit = i;
				if (last_hit < 0)
					pending_replies.push_back(make_reply(1'b0, 1'b0, '0, '0, 1'b1));
				for (int i = 0; i < 64; i++)
					if (hits[i])
						pending_replies.push_back(make_reply(1'b0, 1'b1, i[5:0], '0,
							i == last_hit));
			end
			default: pending_replies.push_back(make_reply(1'b0, 1'b0, '0, '0, 1'b1));
		endcase
	endtask

	// Offers one item after a random gap and waits for its transfer.
	// Valid is left high afterwards so that a zero gap gives back-to-back items.
	task automatic offer_request(input request_t rq);
		int gap;
		gap = $urandom_range(0, 19);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		drive_req <= rq;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_table_op(rq);
	endtask

	// Waits until every expected reply has come, plus the longest item time.
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (140) @(posedge clk);
	endtask

	task automatic write_coords(input int value);
		cfg_we <= 1'b1;
		cfg_wdata <= value[CFG_BITS-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		coords_cfg = value;
	endtask

	// Tags drawn from a tiny alphabet so that patterns actually agree, with wildcards mixed in.
	function automatic logic [15:0] pick_tag();
		case ($urandom_range(0, 7))
			0, 1: return TAG_UNKNOWN;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 3));
		endcase
	endfunction

	function automatic request_t random_request();
		request_t rq;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			rq.func = FUNC_INSERT;
		else if (pick < 75)
			rq.func = FUNC_SELECT;
		else if (pick < 97)
			rq.func = FUNC_REMOVE;
		else
			rq.func = FUNC_UNUSED;
		// A narrow index range gives duplicates, so removes drop several at once.
		rq.entry_index = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 11));
		rq.tag_0 = pick_tag();
		rq.tag_1 = pick_tag();
		rq.tag_2 = pick_tag();
		rq.tag_3 = pick_tag();
		return rq;
	endfunction

	function automatic stim_row_t row(logic [1:0] f, logic [5:0] ix, logic [15:0] t0,
			logic [15:0] t1, logic [15:0] t2, logic [15:0] t3, logic known, reply_t r);
		stim_row_t x;
		x.req = {f, ix, t0, t1, t2, t3};
		x.known = known;
		x.reply = r;
		return x;
	endfunction

	// Receiver: a random wait before each reply, and one long hold-off to back the block up.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_wait <= 0;
		end else if (long_hold) begin
			out_ready <= 1'b0;
		end else if (out_valid && out_ready) begin
			out_ready <= 1'b0;
			out_wait <= $urandom_range(0, 19);
		end else if (out_wait > 0) begin
			out_ready <= 1'b0;
			out_wait <= out_wait - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		wait (arst_n);
		repeat (2000) @(posedge clk);
		long_hold <= 1'b1;
		repeat (1500) @(posedge clk);
		long_hold <= 1'b0;
	end

	// Compare each reply transfer with the oldest expectation.
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected reply %p", got);
			end else begin
				want = pending_replies.pop_front();
				if (want !== got) begin
					mismatches++;
					if (mismatches <= 10)
						$display("reply differs: expected %p, got %p", want, got);
				end
			end
		end
	end

	// Directed rows: the table starts empty, so the first few replies are obvious.
	initial begin
		stim_row_t rows [DIRECTED_ROWS];
		reply_t plain;
		plain = make_reply(1'b0, 1'b0, '0, '0, 1'b1);
		rows[0] = row(FUNC_SELECT, 6'd0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1, plain);
		rows[1] = row(FUNC_REMOVE, 6'd63, '0, '0, '0, '0, 1'b1, plain);
		rows[2] = row(FUNC_UNUSED, 6'd63, '1, '1, '1, '1, 1'b1, plain);
		rows[3] = row(FUNC_INSERT, 6'd63, 16'hFFFE, 16'h0, TAG_UNKNOWN, 16'h1, 1'b1, plain);
		rows[4] = row(FUNC_INSERT, 6'd0, 16'h0, 16'hFFFE, 16'h1, TAG_UNKNOWN, 1'b1, plain);
		rows[5] = row(FUNC_INSERT, 6'd5, 16'h5, 16'h5, 16'h5, 16'h5, 1'b1, plain);
		rows[6] = row(FUNC_INSERT, 6'd5, TAG_UNKNOWN, 16'h7, 16'h7, 16'h7, 1'b1, plain);
		rows[7] = row(FUNC_SELECT, 6'd9, TAG_UNKNOWN, TAG_UNKNOWN, TAG_UNKNOWN,
			TAG_UNKNOWN, 1'b0, plain);
		rows[8] = row(FUNC_SELECT, 6'd0, 16'h5, 16'h5, 16'h5, 16'h5, 1'b0, plain);
		rows[9] = row(FUNC_SELECT, 6'd0, 16'h0, 16'hFFFE, 16'h1, 16'h1234, 1'b0, plain);
		rows[10] = row(FUNC_SELECT, 6'd0, 16'h9, 16'h7, 16'h7, 16'h7, 1'b0, plain);
		rows[11] = row(FUNC_SELECT, 6'd0, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 1'b1, plain);
		rows[12] = row(FUNC_REMOVE, 6'd5, '0, '0, '0, '0, 1'b1,
			make_reply(1'b0, 1'b0, '0, 7'd2, 1'b1));
		rows[13] = row(FUNC_SELECT, 6'd0, 16'h5, 16'h5, 16'h5, 16'h5, 1'b1, plain);
		rows[14] = row(FUNC_INSERT, 6'd0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1, plain);
		rows[15] = row(FUNC_SELECT, 6'd0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, plain);
		rows[16] = row(FUNC_REMOVE, 6'd0, '0, '0, '0, '0, 1'b1,
			make_reply(1'b0, 1'b0, '0, 7'd2, 1'b1));
		rows[17] = row(FUNC_REMOVE, 6'd63, '0, '0, '0, '0, 1'b1,
			make_reply(1'b0, 1'b0, '0, 7'd1, 1'b1));
		rows[18] = row(FUNC_SELECT, 6'd63, 16'h2A, 16'h15, 16'h0, 16'h0, 1'b1, plain);
		rows[19] = row(FUNC_UNUSED, 6'd0, '0, '0, '0, '0, 1'b1, plain);

		for (int s = 0; s < 64; s++)
			slot_used[s] = 1'b0;
		coords_cfg = 4;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			offer_request(rows[r].req);
			// The typed-in reply must agree with the predictor as well.
			if (rows[r].known && pending_replies[pending_replies.size() - 1] !== rows[r].reply) begin
				mismatches++;
				if (mismatches <= 10)
					$display("row %0d: predicted %p, table says %p", r,
						pending_replies[pending_replies.size() - 1], rows[r].reply);
			end
		end
		drain_and_settle();

		// Fill every slot and push one more to see the full rejection, then clear it all.
		write_coords(0);
		for (int k = 0; k < 65; k++)
			offer_request({FUNC_INSERT, 6'(k % 8), pick_tag(), pick_tag(), pick_tag(),
				pick_tag()});
		offer_request({FUNC_SELECT, 6'd0, 16'h1, 16'h2, 16'h3, 16'h4});
		for (int k = 0; k < 8; k++)
			offer_request({FUNC_REMOVE, 6'(k), 16'h0, 16'h0, 16'h0, 16'h0});
		drain_and_settle();

		// Random phases, one per coordinate setting including values past the limit.
		for (int ph = 0; ph < 8; ph++) begin
			write_coords(ph);
			for (int k = 0; k < RANDOM_ITEMS / 8; k++)
				offer_request(random_request());
			drain_and_settle();
		end
		write_coords(4);
		stimulus_done = 1'b1;
	end

	initial begin
		wait (stimulus_done);
		if (mismatches == 0 && pending_replies.size() == 0)
			$display("wildcard_pattern_select_table: match");
		else
			$display("wildcard_pattern_select_table: mismatch");
		$finish;
	end

	initial begin
		#40000000;
		$display("wildcard_pattern_select_table: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
